@@ hdl/sbc_pkg.sv @@
// sbc_pkg: widths, fixed-point formats, saturation limits and codes shared by
// the swept box collision pipeline and the bench; the slab divider takes its widths as parameters.
// No dependencies.
package sbc_pkg;

  // fixed-point formats
  localparam int COORD_FRAC_BITS = 8;
  localparam int TIME_FRAC_BITS  = 16;
  localparam int FT_BITS         = 16;

  // port widths
  localparam int POS_W  = 24;
  localparam int SIZE_W = 23;
  localparam int FT_W   = 16;
  localparam int CT_W   = 16;
  localparam int NRM_W  = 2;
  localparam int HT_W   = TIME_FRAC_BITS + 2;

  // slab numerators and step vector
  localparam int NUM_W  = POS_W + 2;
  localparam int NUMA_W = NUM_W - 1;
  localparam int DEN_W  = POS_W + FT_W;
  localparam int DENA_W = DEN_W - 1;

  // slab divider: quotient bits, initial alignment, pipeline depth
  localparam int Q_W     = TIME_FRAC_BITS + 3;
  localparam int DIV_SH  = FT_BITS + TIME_FRAC_BITS - Q_W;
  localparam int DIV_LAT = Q_W + 1;

  // signed slab times
  localparam int TW = TIME_FRAC_BITS + 4;
  localparam logic [Q_W-1:0] T_BIG = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [TW-1:0] T_ONE = TW'(longint'(1) << TIME_FRAC_BITS);
  localparam logic signed [TW-1:0] T_LOW = TW'(-(longint'(1) << (TIME_FRAC_BITS + 1)));

  // contact point arithmetic
  localparam int P_W    = FT_W + HT_W;
  localparam int PROD_W = POS_W + P_W;
  localparam int BASE_W = NUM_W + FT_BITS - 1;
  localparam int V_W    = PROD_W - TIME_FRAC_BITS + 1;
  localparam int PIX_SH = COORD_FRAC_BITS + FT_BITS;
  localparam int PX_W   = V_W + 1 - PIX_SH;
  localparam logic [V_W:0] PIX_HALF = (V_W + 1)'(1) << (PIX_SH - 1);
  localparam logic [PX_W-1:0] CT_MAX     = PX_W'((1 << (CT_W - 1)) - 1);
  localparam logic [PX_W-1:0] CT_MIN_MAG = PX_W'(1 << (CT_W - 1));
  localparam logic signed [CT_W-1:0] CT_HI = {1'b0, {(CT_W-1){1'b1}}};
  localparam logic signed [CT_W-1:0] CT_LO = {1'b1, {(CT_W-1){1'b0}}};

  // contact normal codes
  localparam logic signed [NRM_W-1:0] NRM_NONE = NRM_W'(0);
  localparam logic signed [NRM_W-1:0] NRM_POS  = NRM_W'(1);
  localparam logic signed [NRM_W-1:0] NRM_NEG  = NRM_W'(-1);

  // side data that travels alongside the slab divisions
  typedef struct packed {
    logic signed [POS_W-1:0] mx;
    logic signed [POS_W-1:0] my;
    logic [SIZE_W-1:0]       mw;
    logic [SIZE_W-1:0]       mh;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic [FT_W-1:0]         ft;
    logic                    vzero;
    logic                    nan;
    logic                    dneg_x;
    logic                    dneg_y;
    logic [3:0]              neg;
  } sbc_side_t;

endpackage

@@ hdl/sbc_div.sv @@
// sbc_div: pipelined restoring divider for one slab time, one quotient bit
// per stage, with an up-front overflow flag.
// Depends on nothing; widths come from the instantiating level.
module sbc_div #(
  parameter int A_W = 25,
  parameter int B_W = 39,
  parameter int Q_W = 19,
  parameter int SH  = 13
) (
  input  logic           clk,
  input  logic           en,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic [Q_W-1:0] q,
  output logic           sat
);

  localparam int R_W = B_W + 1;

  logic [R_W-1:0] r  [Q_W];
  logic [B_W-1:0] dv [Q_W];
  logic [Q_W-1:0] qp [Q_W+1];
  logic           sp [Q_W+1];
  logic [R_W-1:0] r_init;

  // align the dividend; overflow when the quotient would not fit in Q_W bits
  assign r_init = R_W'({a, {SH{1'b0}}});

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= r_init;
      dv[0] <= b;
      qp[0] <= '0;
      sp[0] <= (r_init >= R_W'(b));
    end
  end

  // one restoring step per stage
  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [R_W-1:0] rs;
    logic [R_W-1:0] df;
    logic           ge;

    assign rs = {r[i][R_W-2:0], 1'b0};
    assign ge = (rs >= {1'b0, dv[i]});
    assign df = rs - {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        qp[i+1] <= {qp[i][Q_W-2:0], ge};
        sp[i+1] <= sp[i];
      end
    end

    if (i < Q_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          r[i+1]  <= ge ? df : rs;
          dv[i+1] <= dv[i];
        end
      end
    end
  end

  assign q   = qp[Q_W];
  assign sat = sp[Q_W];

endmodule

@@ hdl/swept_box_collision.sv @@
// swept_box_collision: swept box test as a ray against slabs, one request per
// cycle. Pipeline of 2 set-up stages, 20 divider stages and 9 result stages.
// Throughput one request per cycle; the depth is set by the bit-per-stage slab
// dividers. The whole pipeline holds while a result waits at the output.
// Reset clears all valid bits; payload registers are not reset.
// Depends on sbc_pkg and sbc_div.
module swept_box_collision (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sbc_pkg::POS_W-1:0]     mover_x,
  input  logic signed [sbc_pkg::POS_W-1:0]     mover_y,
  input  logic        [sbc_pkg::SIZE_W-1:0]    mover_w,
  input  logic        [sbc_pkg::SIZE_W-1:0]    mover_h,
  input  logic signed [sbc_pkg::POS_W-1:0]     vel_x,
  input  logic signed [sbc_pkg::POS_W-1:0]     vel_y,
  input  logic signed [sbc_pkg::POS_W-1:0]     target_x,
  input  logic signed [sbc_pkg::POS_W-1:0]     target_y,
  input  logic        [sbc_pkg::SIZE_W-1:0]    target_w,
  input  logic        [sbc_pkg::SIZE_W-1:0]    target_h,
  input  logic        [sbc_pkg::FT_W-1:0]      frame_time,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic signed [sbc_pkg::CT_W-1:0]      contact_x,
  output logic signed [sbc_pkg::CT_W-1:0]      contact_y,
  output logic signed [sbc_pkg::NRM_W-1:0]     normal_x,
  output logic signed [sbc_pkg::NRM_W-1:0]     normal_y,
  output logic signed [sbc_pkg::HT_W-1:0]      hit_time
);

  localparam int NUM_W   = sbc_pkg::NUM_W;
  localparam int NUMA_W  = sbc_pkg::NUMA_W;
  localparam int DEN_W   = sbc_pkg::DEN_W;
  localparam int DENA_W  = sbc_pkg::DENA_W;
  localparam int Q_W     = sbc_pkg::Q_W;
  localparam int DIV_LAT = sbc_pkg::DIV_LAT;
  localparam int TW      = sbc_pkg::TW;
  localparam int HT_W    = sbc_pkg::HT_W;
  localparam int P_W     = sbc_pkg::P_W;
  localparam int PROD_W  = sbc_pkg::PROD_W;
  localparam int BASE_W  = sbc_pkg::BASE_W;
  localparam int V_W     = sbc_pkg::V_W;
  localparam int PX_W    = sbc_pkg::PX_W;
  localparam int CT_W    = sbc_pkg::CT_W;
  localparam int NRM_W   = sbc_pkg::NRM_W;
  localparam int PIX_SH  = sbc_pkg::PIX_SH;
  localparam int TFB     = sbc_pkg::TIME_FRAC_BITS;

  // global advance: hold everything while the output result is not taken
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------- stage s1
  logic signed [NUM_W-1:0] s1_num [4];
  logic signed [DEN_W-1:0] s1_den [2];
  sbc_pkg::sbc_side_t      s1_side;
  logic                    s1_vld;

  logic signed [DEN_W:0]   dx_full;
  logic signed [DEN_W:0]   dy_full;
  logic signed [NUM_W-1:0] num_in [4];
  sbc_pkg::sbc_side_t      side_in;

  // step vector and slab edge distances
  always_comb begin
    dx_full   = vel_x * $signed({1'b0, frame_time});
    dy_full   = vel_y * $signed({1'b0, frame_time});
    num_in[0] = NUM_W'(target_x) - NUM_W'(mover_x) - NUM_W'(mover_w);
    num_in[1] = NUM_W'(target_x) + NUM_W'(target_w) - NUM_W'(mover_x);
    num_in[2] = NUM_W'(target_y) - NUM_W'(mover_y) - NUM_W'(mover_h);
    num_in[3] = NUM_W'(target_y) + NUM_W'(target_h) - NUM_W'(mover_y);
    side_in        = '0;
    side_in.mx     = mover_x;
    side_in.my     = mover_y;
    side_in.mw     = mover_w;
    side_in.mh     = mover_h;
    side_in.vx     = vel_x;
    side_in.vy     = vel_y;
    side_in.ft     = frame_time;
    side_in.vzero  = (vel_x == '0) && (vel_y == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 4; g++) begin
        s1_num[g] <= num_in[g];
      end
      s1_den[0] <= dx_full[DEN_W-1:0];
      s1_den[1] <= dy_full[DEN_W-1:0];
      s1_side   <= side_in;
    end
  end

  // ---------------------------------------------------------------- stage s2
  logic [NUMA_W-1:0]  s2_a [4];
  logic [DENA_W-1:0]  s2_b [2];
  sbc_pkg::sbc_side_t s2_side;
  logic               s2_vld;

  logic [NUMA_W-1:0]  a_in [4];
  logic [DENA_W-1:0]  b_in [2];
  logic [NUM_W-1:0]   num_abs [4];
  logic [DEN_W-1:0]   den_abs [2];
  sbc_pkg::sbc_side_t side2;

  // magnitudes, quotient signs and zero-over-zero detect
  always_comb begin
    side2        = s1_side;
    side2.nan    = 1'b0;
    side2.dneg_x = s1_den[0][DEN_W-1];
    side2.dneg_y = s1_den[1][DEN_W-1];
    for (int d = 0; d < 2; d++) begin
      den_abs[d] = s1_den[d][DEN_W-1] ? -s1_den[d] : s1_den[d];
      b_in[d]    = den_abs[d][DENA_W-1:0];
    end
    for (int g = 0; g < 4; g++) begin
      num_abs[g]   = s1_num[g][NUM_W-1] ? -s1_num[g] : s1_num[g];
      a_in[g]      = num_abs[g][NUMA_W-1:0];
      side2.neg[g] = s1_num[g][NUM_W-1] ^ s1_den[g/2][DEN_W-1];
      if ((s1_num[g] == '0) && (s1_den[g/2] == '0)) begin
        side2.nan = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 4; g++) begin
        s2_a[g] <= a_in[g];
      end
      s2_b[0] <= b_in[0];
      s2_b[1] <= b_in[1];
      s2_side <= side2;
    end
  end

  // ---------------------------------------------------------- slab dividers
  logic [Q_W-1:0] dq   [4];
  logic           dsat [4];

  for (genvar g = 0; g < 4; g++) begin : g_div
    sbc_div #(
      .A_W (NUMA_W),
      .B_W (DENA_W),
      .Q_W (Q_W),
      .SH  (sbc_pkg::DIV_SH)
    ) u_div (
      .clk (clk),
      .en  (en),
      .a   (s2_a[g]),
      .b   (s2_b[g/2]),
      .q   (dq[g]),
      .sat (dsat[g])
    );
  end

  // side data delay matched to the dividers
  sbc_pkg::sbc_side_t dside [DIV_LAT];
  logic [DIV_LAT-1:0] dvld;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= '0;
    end else if (en) begin
      dvld <= {dvld[DIV_LAT-2:0], s2_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside[0] <= s2_side;
      for (int i = 1; i < DIV_LAT; i++) begin
        dside[i] <= dside[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage c1
  logic signed [TW-1:0] c1_t [4];
  sbc_pkg::sbc_side_t   c1_side;
  logic                 c1_vld;

  logic [Q_W-1:0]       qmag [4];
  logic signed [TW-1:0] t_in [4];

  // clamp to the infinite time and apply the sign
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      qmag[g] = (dsat[g] || (dq[g] > sbc_pkg::T_BIG)) ? sbc_pkg::T_BIG : dq[g];
      t_in[g] = dside[DIV_LAT-1].neg[g] ? -$signed(TW'(qmag[g])) : $signed(TW'(qmag[g]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld <= 1'b0;
    end else if (en) begin
      c1_vld <= dvld[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 4; g++) begin
        c1_t[g] <= t_in[g];
      end
      c1_side <= dside[DIV_LAT-1];
    end
  end

  // ---------------------------------------------------------------- stage c2
  logic signed [TW-1:0] c2_nx, c2_fx, c2_ny, c2_fy;
  sbc_pkg::sbc_side_t   c2_side;
  logic                 c2_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_vld <= 1'b0;
    end else if (en) begin
      c2_vld <= c1_vld;
    end
  end

  // order near and far per axis
  always_ff @(posedge clk) begin
    if (en) begin
      c2_nx   <= (c1_t[0] > c1_t[1]) ? c1_t[1] : c1_t[0];
      c2_fx   <= (c1_t[0] > c1_t[1]) ? c1_t[0] : c1_t[1];
      c2_ny   <= (c1_t[2] > c1_t[3]) ? c1_t[3] : c1_t[2];
      c2_fy   <= (c1_t[2] > c1_t[3]) ? c1_t[2] : c1_t[3];
      c2_side <= c1_side;
    end
  end

  // ---------------------------------------------------------------- stage c3
  logic signed [TW-1:0] c3_tn, c3_tf;
  logic                 c3_ovl, c3_gt, c3_lt;
  sbc_pkg::sbc_side_t   c3_side;
  logic                 c3_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_vld <= 1'b0;
    end else if (en) begin
      c3_vld <= c2_vld;
    end
  end

  // slab overlap, entry and exit times, normal axis
  always_ff @(posedge clk) begin
    if (en) begin
      c3_ovl  <= (c2_nx > c2_fy) || (c2_ny > c2_fx);
      c3_tn   <= (c2_nx > c2_ny) ? c2_nx : c2_ny;
      c3_tf   <= (c2_fx < c2_fy) ? c2_fx : c2_fy;
      c3_gt   <= (c2_nx > c2_ny);
      c3_lt   <= (c2_nx < c2_ny);
      c3_side <= c2_side;
    end
  end

  // ---------------------------------------------------------------- stage c4
  logic                     c4_hit;
  logic signed [HT_W-1:0]   c4_ht;
  logic signed [NRM_W-1:0]  c4_nrx, c4_nry;
  sbc_pkg::sbc_side_t       c4_side;
  logic                     c4_vld;

  logic                     hit_in;
  logic signed [TW-1:0]     ht_full;
  logic signed [NRM_W-1:0]  nrx_in, nry_in;

  // hit decision, low saturation of the entry time, normals
  always_comb begin
    hit_in = !c3_side.vzero && !c3_side.nan && !c3_ovl &&
             !c3_tf[TW-1] && !(c3_tn > sbc_pkg::T_ONE);
    ht_full = (c3_tn < sbc_pkg::T_LOW) ? sbc_pkg::T_LOW : c3_tn;
    nrx_in  = sbc_pkg::NRM_NONE;
    nry_in  = sbc_pkg::NRM_NONE;
    if (hit_in && c3_gt) begin
      nrx_in = c3_side.dneg_x ? sbc_pkg::NRM_POS : sbc_pkg::NRM_NEG;
    end else if (hit_in && c3_lt) begin
      nry_in = c3_side.dneg_y ? sbc_pkg::NRM_POS : sbc_pkg::NRM_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c4_vld <= 1'b0;
    end else if (en) begin
      c4_vld <= c3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_hit  <= hit_in;
      c4_ht   <= hit_in ? ht_full[HT_W-1:0] : '0;
      c4_nrx  <= nrx_in;
      c4_nry  <= nry_in;
      c4_side <= c3_side;
    end
  end

  // ---------------------------------------------------------------- stage c5
  logic signed [P_W-1:0]    c5_p;
  logic signed [BASE_W-1:0] c5_base [2];
  logic signed [sbc_pkg::POS_W-1:0] c5_vx, c5_vy;
  logic                     c5_hit;
  logic signed [HT_W-1:0]   c5_ht;
  logic signed [NRM_W-1:0]  c5_nrx, c5_nry;
  logic                     c5_vld;

  logic signed [P_W:0]      p_full;
  logic signed [NUM_W-1:0]  ctr_x, ctr_y;

  // frame time times hit time, and box centres at double scale
  always_comb begin
    p_full = $signed({1'b0, c4_side.ft}) * c4_ht;
    ctr_x  = NUM_W'(c4_side.mx) + NUM_W'(c4_side.mx) + NUM_W'(c4_side.mw);
    ctr_y  = NUM_W'(c4_side.my) + NUM_W'(c4_side.my) + NUM_W'(c4_side.mh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c5_vld <= 1'b0;
    end else if (en) begin
      c5_vld <= c4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5_p       <= p_full[P_W-1:0];
      c5_base[0] <= BASE_W'(ctr_x) <<< (sbc_pkg::FT_BITS - 1);
      c5_base[1] <= BASE_W'(ctr_y) <<< (sbc_pkg::FT_BITS - 1);
      c5_vx      <= c4_side.vx;
      c5_vy      <= c4_side.vy;
      c5_hit     <= c4_hit;
      c5_ht      <= c4_ht;
      c5_nrx     <= c4_nrx;
      c5_nry     <= c4_nry;
    end
  end

  // ---------------------------------------------------------------- stage c6
  logic signed [PROD_W-1:0] c6_prod [2];
  logic signed [BASE_W-1:0] c6_base [2];
  logic                     c6_hit;
  logic signed [HT_W-1:0]   c6_ht;
  logic signed [NRM_W-1:0]  c6_nrx, c6_nry;
  logic                     c6_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      c6_vld <= 1'b0;
    end else if (en) begin
      c6_vld <= c5_vld;
    end
  end

  // offset along the step: velocity times frame time times hit time
  always_ff @(posedge clk) begin
    if (en) begin
      c6_prod[0] <= c5_vx * c5_p;
      c6_prod[1] <= c5_vy * c5_p;
      c6_base[0] <= c5_base[0];
      c6_base[1] <= c5_base[1];
      c6_hit     <= c5_hit;
      c6_ht      <= c5_ht;
      c6_nrx     <= c5_nrx;
      c6_nry     <= c5_nry;
    end
  end

  // ---------------------------------------------------------------- stage c7
  logic signed [V_W-1:0]    c7_v [2];
  logic                     c7_hit;
  logic signed [HT_W-1:0]   c7_ht;
  logic signed [NRM_W-1:0]  c7_nrx, c7_nry;
  logic                     c7_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      c7_vld <= 1'b0;
    end else if (en) begin
      c7_vld <= c6_vld;
    end
  end

  // centre plus floored offset
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        c7_v[k] <= V_W'(c6_base[k]) + V_W'(c6_prod[k] >>> TFB);
      end
      c7_hit <= c6_hit;
      c7_ht  <= c6_ht;
      c7_nrx <= c6_nrx;
      c7_nry <= c6_nry;
    end
  end

  // ---------------------------------------------------------------- stage c8
  logic [V_W-1:0]           c8_mag [2];
  logic                     c8_neg [2];
  logic                     c8_hit;
  logic signed [HT_W-1:0]   c8_ht;
  logic signed [NRM_W-1:0]  c8_nrx, c8_nry;
  logic                     c8_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      c8_vld <= 1'b0;
    end else if (en) begin
      c8_vld <= c7_vld;
    end
  end

  // sign and magnitude for rounding away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        c8_neg[k] <= c7_v[k][V_W-1];
        c8_mag[k] <= c7_v[k][V_W-1] ? V_W'(-c7_v[k]) : V_W'(c7_v[k]);
      end
      c8_hit <= c7_hit;
      c8_ht  <= c7_ht;
      c8_nrx <= c7_nrx;
      c8_nry <= c7_nry;
    end
  end

  // ------------------------------------------------------------ output stage
  logic [V_W:0]            rnd [2];
  logic [PX_W-1:0]         px  [2];
  logic signed [CT_W-1:0]  ct  [2];

  // round to a pixel and saturate to 16 bits
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rnd[k] = {1'b0, c8_mag[k]} + sbc_pkg::PIX_HALF;
      px[k]  = rnd[k][V_W:PIX_SH];
      if (!c8_hit) begin
        ct[k] = '0;
      end else if (c8_neg[k]) begin
        ct[k] = (px[k] > sbc_pkg::CT_MIN_MAG) ? sbc_pkg::CT_LO : -$signed(CT_W'(px[k]));
      end else begin
        ct[k] = (px[k] > sbc_pkg::CT_MAX) ? sbc_pkg::CT_HI : $signed(CT_W'(px[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c8_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit       <= c8_hit;
      contact_x <= ct[0];
      contact_y <= ct[1];
      normal_x  <= c8_nrx;
      normal_y  <= c8_nry;
      hit_time  <= c8_ht;
    end
  end

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for swept_box_collision, a swept box against a still box
// checked against a fixed-point slab-test predictor written here. Depends on sbc_pkg.
`timescale 1ns / 1ps
module tb;

  localparam int COORD_FRAC_BITS = sbc_pkg::COORD_FRAC_BITS;
  localparam int TIME_FRAC_BITS  = sbc_pkg::TIME_FRAC_BITS;
  localparam int FT_BITS         = sbc_pkg::FT_BITS;
  localparam int POS_W           = sbc_pkg::POS_W;
  localparam int SIZE_W          = sbc_pkg::SIZE_W;
  localparam int FT_W            = sbc_pkg::FT_W;
  localparam int CT_W            = sbc_pkg::CT_W;
  localparam int NRM_W           = sbc_pkg::NRM_W;
  localparam int HT_W            = sbc_pkg::HT_W;

  typedef struct {
    logic signed [POS_W-1:0] mx, my, vx, vy, tx, ty;
    logic [SIZE_W-1:0]       mw, mh, tw, th;
    logic [FT_W-1:0]         ft;
  } box_req_t;

  typedef struct {
    logic                    hit;
    logic signed [CT_W-1:0]  cx, cy;
    logic signed [NRM_W-1:0] nx, ny;
    logic signed [HT_W-1:0]  ht;
  } contact_t;

  localparam longint TONE = longint'(1) << TIME_FRAC_BITS;
  localparam longint TBIG = longint'(1) << (TIME_FRAC_BITS + 2);
  localparam longint TLOW = -(longint'(1) << (TIME_FRAC_BITS + 1));

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [POS_W-1:0] mover_x = 0, mover_y = 0, vel_x = 0, vel_y = 0;
  logic signed [POS_W-1:0] target_x = 0, target_y = 0;
  logic [SIZE_W-1:0] mover_w = 0, mover_h = 0, target_w = 0, target_h = 0;
  logic [FT_W-1:0] frame_time = 0;
  logic hit;
  logic signed [CT_W-1:0] contact_x, contact_y;
  logic signed [NRM_W-1:0] normal_x, normal_y;
  logic signed [HT_W-1:0] hit_time;

  box_req_t pending_reqs[$];
  contact_t expected_contacts[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  bit stim_done = 0;
  bit in_taken = 0;

  swept_box_collision u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // slab time: num with coordinate fraction, den with coordinate + frame fraction
  function automatic longint slab_time(longint num, longint den, ref bit nan);
    longint a, b, q, r;
    bit sat;
    if (den == 0) begin
      if (num == 0) nan = 1;
      return num == 0 ? 0 : (num > 0 ? TBIG : -TBIG);
    end
    a = num < 0 ? -num : num;
    b = den < 0 ? -den : den;
    q = a / b;
    r = a % b;
    sat = q > TBIG;
    for (int i = 0; i < FT_BITS + TIME_FRAC_BITS && !sat; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        q++;
        r -= b;
      end
      if (q > TBIG) sat = 1;
    end
    if (sat) q = TBIG;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic longint floor_sh(longint v, int s);
    return v >= 0 ? v >>> s : -((-v + ((longint'(1) << s) - 1)) >>> s);
  endfunction

  function automatic logic signed [CT_W-1:0] contact_px(longint pos, longint size,
                                                         longint d, longint t);
    longint ti, tf, v, mag, px;
    int sh;
    sh = COORD_FRAC_BITS + FT_BITS;
    ti = floor_sh(t, TIME_FRAC_BITS);
    tf = t - ti * TONE;
    v = (2 * pos + size) * (longint'(1) << (FT_BITS - 1));
    v += d * ti + floor_sh(d * tf, TIME_FRAC_BITS);
    mag = v < 0 ? -v : v;
    px = (mag + (longint'(1) << (sh - 1))) >>> sh;
    if (px > 32767 && v >= 0) px = 32767;
    if (px > 32768) px = 32768;
    return CT_W'(v < 0 ? -px : px);
  endfunction

  function automatic contact_t sweep_boxes(box_req_t q);
    contact_t c;
    longint dx, dy, nx, fx, ny, fy, tn, tf, ht, s;
    bit nan;
    c = '{default: 0};
    nan = 0;
    if (q.vx == 0 && q.vy == 0) return c;
    dx = longint'(q.vx) * longint'(q.ft);
    dy = longint'(q.vy) * longint'(q.ft);
    nx = slab_time(longint'(q.tx) - longint'(q.mx) - longint'(q.mw), dx, nan);
    fx = slab_time(longint'(q.tx) + longint'(q.tw) - longint'(q.mx), dx, nan);
    ny = slab_time(longint'(q.ty) - longint'(q.my) - longint'(q.mh), dy, nan);
    fy = slab_time(longint'(q.ty) + longint'(q.th) - longint'(q.my), dy, nan);
    if (nan) return c;
    if (nx > fx) begin s = nx; nx = fx; fx = s; end
    if (ny > fy) begin s = ny; ny = fy; fy = s; end
    if (nx > fy || ny > fx) return c;
    tn = nx > ny ? nx : ny;
    tf = fx < fy ? fx : fy;
    if (tf < 0 || tn > TONE) return c;
    ht = tn < TLOW ? TLOW : tn;
    if (nx > ny) c.nx = dx < 0 ? sbc_pkg::NRM_POS : sbc_pkg::NRM_NEG;
    else if (nx < ny) c.ny = dy < 0 ? sbc_pkg::NRM_POS : sbc_pkg::NRM_NEG;
    c.hit = 1;
    c.cx = contact_px(q.mx, q.mw, dx, ht);
    c.cy = contact_px(q.my, q.mh, dy, ht);
    c.ht = HT_W'(ht);
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic box_req_t rand_req(bit near);
    box_req_t q;
    q.mx = POS_W'($urandom); q.my = POS_W'($urandom);
    q.vx = POS_W'($urandom); q.vy = POS_W'($urandom);
    q.tx = POS_W'($urandom); q.ty = POS_W'($urandom);
    q.mw = SIZE_W'($urandom); q.mh = SIZE_W'($urandom);
    q.tw = SIZE_W'($urandom); q.th = SIZE_W'($urandom);
    q.ft = FT_W'($urandom);
    if (near) begin
      // closing pair in a small world, so hits are common
      q.mx = POS_W'($signed($urandom_range(0, 40000)) - 20000);
      q.my = POS_W'($signed($urandom_range(0, 40000)) - 20000);
      q.tx = POS_W'(int'(q.mx) + $signed($urandom_range(0, 20000)) - 10000);
      q.ty = POS_W'(int'(q.my) + $signed($urandom_range(0, 20000)) - 10000);
      q.mw = SIZE_W'($urandom_range(0, 4000)); q.mh = SIZE_W'($urandom_range(0, 4000));
      q.tw = SIZE_W'($urandom_range(0, 8000)); q.th = SIZE_W'($urandom_range(0, 8000));
      q.vx = POS_W'((int'(q.tx) - int'(q.mx)) * $signed($urandom_range(1, 8)));
      q.vy = POS_W'((int'(q.ty) - int'(q.my)) * $signed($urandom_range(1, 8)));
      if ($urandom_range(0, 5) == 0) q.vx = 0;
      if ($urandom_range(0, 5) == 0) q.vy = 0;
      q.ft = FT_W'($urandom_range(4096, 65535));
    end
    return q;
  endfunction

  // request driver and random output back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if ((!in_valid || in_taken) && pending_reqs.size() > 0 &&
          $urandom_range(0, 99) >= send_idle) begin
        box_req_t q;
        q = pending_reqs.pop_front();
        mover_x <= q.mx; mover_y <= q.my; mover_w <= q.mw; mover_h <= q.mh;
        vel_x <= q.vx; vel_y <= q.vy; target_x <= q.tx; target_y <= q.ty;
        target_w <= q.tw; target_h <= q.th; frame_time <= q.ft;
        in_valid <= 1;
      end else if (in_taken) begin
        in_valid <= 0;
      end
      out_ready <= $urandom_range(0, 99) >= recv_idle;
    end
  end

  // accept monitor and result checker
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_contacts = {expected_contacts, sweep_boxes('{mover_x, mover_y, vel_x,
          vel_y, target_x, target_y, mover_w, mover_h, target_w, target_h, frame_time})};
      if (out_valid && out_ready) begin
        if (expected_contacts.size() == 0) begin
          $display("unexpected result");
          errors++;
        end else begin
          contact_t e;
          e = expected_contacts.pop_front();
          if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
          if (contact_x !== e.cx) report_mismatch("contact_x", contact_x, e.cx);
          if (contact_y !== e.cy) report_mismatch("contact_y", contact_y, e.cy);
          if (normal_x !== e.nx) report_mismatch("normal_x", normal_x, e.nx);
          if (normal_y !== e.ny) report_mismatch("normal_y", normal_y, e.ny);
          if (hit_time !== e.ht) report_mismatch("hit_time", hit_time, e.ht);
        end
      end
    end
  end

  initial begin
    box_req_t q;
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 0;
    // directed: zero velocity, zero over zero, axis cases, extremes, ties
    q = '{0, 0, 0, 0, 0, 0, 256, 256, 256, 256, 65535};
    pending_reqs = {pending_reqs, q};
    q = '{0, 0, 256, 0, 1024, 0, 256, 256, 256, 256, 32768};
    pending_reqs = {pending_reqs, q};
    q = '{0, 0, 256, 0, 1024, 256, 256, 256, 256, 256, 32768};
    pending_reqs = {pending_reqs, q};
    q = '{0, 0, 0, 256, 0, 1024, 256, 256, 256, 256, 65535};
    pending_reqs = {pending_reqs, q};
    q = '{0, 0, 512, 512, 1024, 1024, 256, 256, 256, 256, 65535};
    pending_reqs = {pending_reqs, q};
    q = '{0, 0, -512, 0, -1024, 0, 256, 256, 256, 256, 65535};
    pending_reqs = {pending_reqs, q};
    q = '{512, 0, 256, 0, 0, 0, 512, 256, 256, 256, 1};
    pending_reqs = {pending_reqs, q};
    q = '{0, 0, 256, 0, 0, 0, 256, 256, 256, 256, 0};
    pending_reqs = {pending_reqs, q};
    q = '{-8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
          8388607, 8388607, 8388607, 8388607, 65535};
    pending_reqs = {pending_reqs, q};
    q = '{8388607, 8388607, -8388608, -8388608, -8388608, -8388608,
          0, 0, 0, 0, 65535};
    pending_reqs = {pending_reqs, q};
    q = '{0, 0, 1, 1, 0, 0, 8388607, 8388607, 8388607, 8388607, 65535};
    pending_reqs = {pending_reqs, q};
    q = '{-8388608, 0, 8388607, 0, 8388607, 0, 0, 0, 0, 0, 65535};
    pending_reqs = {pending_reqs, q};
    q = '{0, 0, 2560, 0, -2560, 0, 256, 256, 256, 256, 65535};
    pending_reqs = {pending_reqs, q};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 21 : (ph == 1 ? 85 : 0);
      recv_idle = ph == 0 ? 85 : (ph == 1 ? 21 : 0);
      for (int i = 0; i < 165; i++)
        pending_reqs = {pending_reqs, rand_req($urandom_range(0, 3) != 0)};
      while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
    end
    while (expected_contacts.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end
endmodule
